@@ design/dppn_pkg.sv @@
package dppn_pkg;

    localparam int NAME_CHARS_DEF = 7;
    localparam int PATH_LIMIT_DEF = 256;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;

    localparam logic [1:0] KIND_NAME   = 2'd0;
    localparam logic [1:0] KIND_DEVICE = 2'd1;
    localparam logic [1:0] KIND_PATH   = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD      = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    typedef enum logic [2:0] {
        PH_NAME,
        PH_DIGIT,
        PH_LEAD,
        PH_BODY,
        PH_ERROR
    } phase_t;

    // one queued request; pre_slash asks the back end for a '/' ahead of it
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [1:0] status;
        logic       last;
        logic       pre_slash;
    } cmd_t;

    typedef struct packed {
        logic head_valid;
        logic not_full;
    } queue_stat_t;

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= CHAR_LO_A) && (c <= CHAR_LO_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic path_char_ok(input logic [7:0] c);
        return is_lower(c) || ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) || is_digit(c)
            || (c == CHAR_UNDER) || (c == CHAR_DOT);
    endfunction

endpackage

@@ design/dppn_in_if.sv @@
interface dppn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] path_byte;

    modport source (output valid, output path_byte, input ready);
    modport sink (input valid, input path_byte, output ready);
endinterface

@@ design/dppn_out_if.sv @@
interface dppn_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output kind, output value, output status, output last,
                    input ready);
    modport sink (input valid, input kind, input value, input status, input last,
                  output ready);
endinterface

@@ design/dppn_front.sv @@
module dppn_front #(
    parameter int NAME_CHARS = dppn_pkg::NAME_CHARS_DEF,
    parameter int PATH_LIMIT = dppn_pkg::PATH_LIMIT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    dppn_in_if.sink               path,
    input  dppn_pkg::queue_stat_t qstat,
    output logic                  push,
    output dppn_pkg::cmd_t        push_cmd
);
    import dppn_pkg::*;

    localparam int NCW = $clog2(NAME_CHARS + 1);
    localparam int SIW = $clog2(PATH_LIMIT + 1);

    phase_t           phase_reg, phase_next;
    logic [NCW-1:0]   name_count_reg, name_count_next;
    logic [SIW-1:0]   source_index_reg, source_index_next;
    logic             slash_pending_reg, slash_pending_next;
    logic [3:0]       device_number_reg, device_number_next;

    logic       accept;
    logic [7:0] c;
    logic       nul;
    logic       emit;
    logic       do_finish;
    logic [1:0] fin_status;
    logic       sp;
    cmd_t       cmd;

    assign path.ready = qstat.not_full;
    assign accept     = path.valid && path.ready;
    assign c          = path.path_byte;
    assign nul        = (c == CHAR_NUL);

    always_comb
    begin
        phase_next         = phase_reg;
        name_count_next    = name_count_reg;
        slash_pending_next = slash_pending_reg;
        device_number_next = device_number_reg;
        source_index_next  = (source_index_reg < SIW'(PATH_LIMIT))
                           ? source_index_reg + 1'b1 : source_index_reg;
        emit       = 1'b0;
        do_finish  = 1'b0;
        fin_status = STATUS_OK;
        sp         = slash_pending_reg;
        cmd        = '{kind: KIND_NAME, value: c, status: STATUS_OK, last: 1'b0,
                       pre_slash: 1'b0};

        unique case (phase_reg)
            PH_NAME:
            begin
                if (is_lower(c) && (name_count_reg < NCW'(NAME_CHARS)))
                begin
                    emit            = 1'b1;
                    name_count_next = name_count_reg + 1'b1;
                end
                else if (name_count_reg == '0)
                begin
                    do_finish  = 1'b1;
                    fin_status = STATUS_BAD;
                end
                else if (c == CHAR_COLON)
                begin
                    emit       = 1'b1;
                    cmd.kind   = KIND_DEVICE;
                    cmd.value  = 8'd0;
                    phase_next = PH_LEAD;
                end
                else if (is_digit(c))
                begin
                    device_number_next = 4'(c - CHAR_ZERO);
                    phase_next         = PH_DIGIT;
                end
                else
                begin
                    do_finish  = 1'b1;
                    fin_status = STATUS_BAD;
                end
            end
            PH_DIGIT:
            begin
                if (c == CHAR_COLON)
                begin
                    emit       = 1'b1;
                    cmd.kind   = KIND_DEVICE;
                    cmd.value  = {4'd0, device_number_reg};
                    phase_next = PH_LEAD;
                end
                else
                begin
                    do_finish  = 1'b1;
                    fin_status = STATUS_BAD;
                end
            end
            PH_LEAD, PH_BODY:
            begin
                if (phase_reg == PH_LEAD)
                begin
                    sp = 1'b0;
                end
                if (!((phase_reg == PH_LEAD) && (c == CHAR_SLASH)))
                begin
                    phase_next         = PH_BODY;
                    slash_pending_next = sp;
                    if (nul)
                    begin
                        do_finish  = 1'b1;
                        fin_status = STATUS_OK;
                    end
                    else if ((c == CHAR_SLASH) && sp)
                    begin
                        slash_pending_next = 1'b1;
                    end
                    else if (source_index_reg >= SIW'(PATH_LIMIT))
                    begin
                        do_finish  = 1'b1;
                        fin_status = STATUS_TOO_LONG;
                    end
                    else if (c == CHAR_SLASH)
                    begin
                        slash_pending_next = 1'b1;
                    end
                    else if (!path_char_ok(c))
                    begin
                        do_finish  = 1'b1;
                        fin_status = STATUS_BAD;
                    end
                    else
                    begin
                        emit               = 1'b1;
                        cmd.kind           = KIND_PATH;
                        cmd.pre_slash      = sp;
                        slash_pending_next = 1'b0;
                    end
                end
            end
            default:
            begin
                if (nul)
                begin
                    phase_next         = PH_NAME;
                    name_count_next    = '0;
                    source_index_next  = '0;
                    slash_pending_next = 1'b0;
                    device_number_next = 4'd0;
                end
            end
        endcase

        if (do_finish)
        begin
            emit = 1'b1;
            cmd  = '{kind: KIND_END, value: 8'd0, status: fin_status, last: 1'b1,
                     pre_slash: 1'b0};
            if (nul)
            begin
                phase_next         = PH_NAME;
                name_count_next    = '0;
                source_index_next  = '0;
                slash_pending_next = 1'b0;
                device_number_next = 4'd0;
            end
            else
            begin
                phase_next = PH_ERROR;
            end
        end
    end

    assign push     = accept && emit;
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_NAME;
            name_count_reg    <= '0;
            source_index_reg  <= '0;
            slash_pending_reg <= 1'b0;
            device_number_reg <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            name_count_reg    <= name_count_next;
            source_index_reg  <= source_index_next;
            slash_pending_reg <= slash_pending_next;
            device_number_reg <= device_number_next;
        end
    end

endmodule

@@ design/dppn_queue.sv @@
module dppn_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  dppn_pkg::cmd_t        push_cmd,
    input  logic                  pop,
    output dppn_pkg::cmd_t        head_cmd,
    output dppn_pkg::queue_stat_t qstat
);
    import dppn_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;

    assign qstat.head_valid = (count_reg != '0);
    assign qstat.not_full   = (count_reg != CW'(QUEUE_DEPTH));
    assign head_cmd         = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= PW'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= PW'(rd_ptr_reg + 1'b1);
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ design/dppn_back.sv @@
module dppn_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dppn_pkg::cmd_t        head_cmd,
    input  dppn_pkg::queue_stat_t qstat,
    output logic                  pop,
    dppn_out_if.source            result
);
    import dppn_pkg::*;

    logic       out_valid_reg;
    logic       half_reg, half_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] value_reg, value_next;
    logic [1:0] status_reg, status_next;
    logic       last_reg, last_next;
    logic       load;

    assign load = qstat.head_valid && (!out_valid_reg || result.ready);

    always_comb
    begin
        pop         = 1'b0;
        half_next   = half_reg;
        kind_next   = head_cmd.kind;
        value_next  = head_cmd.value;
        status_next = head_cmd.status;
        last_next   = head_cmd.last;
        if (load)
        begin
            if (head_cmd.pre_slash && !half_reg)
            begin
                // merged slash goes out ahead of the char that follows it
                kind_next   = KIND_PATH;
                value_next  = CHAR_SLASH;
                status_next = STATUS_OK;
                last_next   = 1'b0;
                half_next   = 1'b1;
            end
            else
            begin
                pop       = 1'b1;
                half_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= kind_next;
            value_reg  <= value_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            half_reg <= half_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.kind   = kind_reg;
    assign result.value  = value_reg;
    assign result.status = status_reg;
    assign result.last   = last_reg;

endmodule

@@ design/device_path_parse_normalize.sv @@
// Device path parser / normalizer.
// path   : request channel, one byte of a NUL-terminated "name[digit]:path"
//          string per request (path_byte).
// result : request channel of results (kind, value, status, last). Name chars,
//          then the device number, then normalized path chars, then one end
//          status with last = 1. After an error, bytes are dropped up to NUL.
// Throughput: one byte per cycle while the queue is not full. A byte that
// releases a merged slash makes two results, which leave the output register
// in turn. A result is registered in the queue, then in the output register.
// The front end parses into a 4-entry request queue; the back end drains it
// into a registered output. path.ready drops only when the queue is full, so
// a stalled receiver holds the output and the queue absorbs 4 more queued
// requests (a merged slash rides with its char) before input backs up.
// Nothing is lost or repeated under stall.
// Reset (rst_n low, async): parser back to the name phase, queue and output
// emptied; no startup sweep.
module device_path_parse_normalize #(
    parameter int NAME_CHARS = dppn_pkg::NAME_CHARS_DEF,
    parameter int PATH_LIMIT = dppn_pkg::PATH_LIMIT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dppn_in_if.sink    path,
    dppn_out_if.source result
);
    import dppn_pkg::*;

    logic        push;
    logic        pop;
    cmd_t        push_cmd;
    cmd_t        head_cmd;
    queue_stat_t qstat;

    dppn_front #(
        .NAME_CHARS (NAME_CHARS),
        .PATH_LIMIT (PATH_LIMIT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .path     (path),
        .qstat    (qstat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    dppn_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .qstat    (qstat)
    );

    dppn_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .qstat    (qstat),
        .pop      (pop),
        .result   (result)
    );

endmodule
